/* rtl/ppgbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppgbd_pkg
// Shared types and constants of the pulse beat detector: configuration set,
// front-to-back event, divider request and response, register map.
// ----------------------------------------------------------------------------
package ppgbd_pkg;

    localparam int RING_DEPTH  = 8;
    localparam int SLOT_W      = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int CNT_W       = $clog2(RING_DEPTH + 1);
    localparam int SUM_W       = 8 + CNT_W;
    localparam int DIV_W       = 16;
    localparam int DIV_STEP_W  = $clog2(DIV_W + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int ADDR_W      = 5;

    localparam logic [DIV_W-1:0]  BPM_NUMERATOR = 16'd60000;
    localparam logic signed [17:0] MAX_RESET    = -18'sd9999;
    localparam logic signed [17:0] MIN_RESET    = 18'sd9999;

    localparam logic [17:0]        PRESENCE_DEFAULT = 18'd100000;
    localparam logic [16:0]        CREST_DEFAULT    = 17'd100;
    localparam logic signed [17:0] TROUGH_DEFAULT   = -18'sd100;
    localparam logic [1:0]         RISE_DEFAULT     = 2'd2;
    localparam logic [7:0]         FLOOR_DEFAULT    = 8'd45;
    localparam logic [7:0]         CEILING_DEFAULT  = 8'd150;

    typedef enum logic [2:0] {
        REG_PRESENCE = 3'd0,
        REG_CREST    = 3'd1,
        REG_TROUGH   = 3'd2,
        REG_RISE     = 3'd3,
        REG_FLOOR    = 3'd4,
        REG_CEILING  = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [17:0]        presence_threshold;
        logic [16:0]        crest_level;
        logic signed [17:0] trough_level;
        logic [1:0]         rise_needed;
        logic [7:0]         bpm_floor;
        logic [7:0]         bpm_ceiling;
    } cfg_t;

    typedef struct packed {
        logic        present;
        logic        beat;
        logic [15:0] ms;
    } event_t;

    typedef struct packed {
        logic             start;
        logic [DIV_W-1:0] dividend;
        logic [DIV_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic [DIV_W-1:0] quotient;
    } div_rsp_t;

endpackage

/* rtl/ppgbd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppgbd_front
// Presence check and crest / trough / rise beat machine, one sample per
// cycle unless the queue is full; pushes one event per sample into the queue.
// ----------------------------------------------------------------------------
module ppgbd_front (
    input  logic               clk,
    input  logic               rst_n,
    input  ppgbd_pkg::cfg_t    cfg,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [17:0]        raw_ir,
    input  logic signed [17:0] filtered_ir,
    input  logic [15:0]        elapsed_ms,
    input  logic               q_full,
    output logic               q_push,
    output ppgbd_pkg::event_t  q_data
);

    logic signed [17:0] prev_reg;
    logic               prev_valid_reg;
    logic               crest_reg;
    logic               trough_reg;
    logic [1:0]         rise_reg;
    logic signed [17:0] max_reg;
    logic signed [17:0] min_reg;
    logic [15:0]        ms_reg;

    logic        present;
    logic [16:0] ms_sum;
    logic [15:0] ms_sat;
    logic        rising;
    logic [1:0]  rise_inc;
    logic        fire;
    logic        max_hit;
    logic        crest_hit;
    logic        crest_after;
    logic        min_hit;
    logic        trough_hit;

    assign in_ready = !q_full;
    assign q_push   = in_valid && in_ready;

    always_comb
    begin
        present     = raw_ir >= cfg.presence_threshold;
        ms_sum      = {1'b0, ms_reg} + {1'b0, elapsed_ms};
        ms_sat      = ms_sum[16] ? 16'hFFFF : ms_sum[15:0];
        rising      = crest_reg && trough_reg && (filtered_ir > prev_reg);
        rise_inc    = rise_reg + 2'd1;
        fire        = prev_valid_reg && rising && (rise_inc >= cfg.rise_needed);
        max_hit     = filtered_ir > max_reg;
        crest_hit   = $signed({filtered_ir[17], filtered_ir}) > $signed({2'b00, cfg.crest_level});
        crest_after = crest_reg || (max_hit && crest_hit);
        min_hit     = crest_after && (filtered_ir < min_reg);
        trough_hit  = filtered_ir < cfg.trough_level;
        q_data      = '{present: present, beat: present && fire, ms: ms_sat};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg       <= '0;
            prev_valid_reg <= 1'b0;
            crest_reg      <= 1'b0;
            trough_reg     <= 1'b0;
            rise_reg       <= '0;
            max_reg        <= ppgbd_pkg::MAX_RESET;
            min_reg        <= ppgbd_pkg::MIN_RESET;
            ms_reg         <= '0;
        end
        else if (q_push)
        begin
            if (!present)
            begin
                prev_reg       <= '0;
                prev_valid_reg <= 1'b0;
                crest_reg      <= 1'b0;
                trough_reg     <= 1'b0;
                rise_reg       <= '0;
                max_reg        <= ppgbd_pkg::MAX_RESET;
                min_reg        <= ppgbd_pkg::MIN_RESET;
                ms_reg         <= '0;
            end
            else
            begin
                prev_reg       <= filtered_ir;
                prev_valid_reg <= 1'b1;
                ms_reg         <= fire ? 16'd0 : ms_sat;
                if (prev_valid_reg)
                begin
                    if (fire)
                    begin
                        crest_reg  <= 1'b0;
                        trough_reg <= 1'b0;
                        rise_reg   <= '0;
                        max_reg    <= ppgbd_pkg::MAX_RESET;
                        min_reg    <= ppgbd_pkg::MIN_RESET;
                    end
                    else
                    begin
                        // rise count only moves up; a fall leaves it as it is
                        if (rising)
                        begin
                            rise_reg <= rise_inc;
                        end
                        if (max_hit)
                        begin
                            max_reg <= filtered_ir;
                        end
                        crest_reg <= crest_after;
                        if (min_hit)
                        begin
                            min_reg <= filtered_ir;
                            if (trough_hit)
                            begin
                                trough_reg <= 1'b1;
                            end
                        end
                    end
                end
            end
        end
    end

endmodule

/* rtl/ppgbd_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppgbd_queue
// Short event queue between the detection front and the rate back end.
// ----------------------------------------------------------------------------
module ppgbd_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  ppgbd_pkg::event_t push_data,
    input  logic              pop,
    output ppgbd_pkg::event_t head,
    output logic              full,
    output logic              empty
);

    ppgbd_pkg::event_t                entry_reg [ppgbd_pkg::QUEUE_DEPTH];
    logic [ppgbd_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [ppgbd_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [ppgbd_pkg::QPTR_W:0]       count_reg;

    logic do_push;
    logic do_pop;

    assign full    = count_reg == (ppgbd_pkg::QPTR_W + 1)'(ppgbd_pkg::QUEUE_DEPTH);
    assign empty   = count_reg == '0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == ppgbd_pkg::QPTR_W'(ppgbd_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == ppgbd_pkg::QPTR_W'(ppgbd_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/ppgbd_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppgbd_div
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ppgbd_div (
    input  logic                clk,
    input  logic                rst_n,
    input  ppgbd_pkg::div_req_t req,
    output ppgbd_pkg::div_rsp_t rsp
);

    logic [ppgbd_pkg::DIV_W-1:0]      rem_reg;
    logic [ppgbd_pkg::DIV_W-1:0]      quo_reg;
    logic [ppgbd_pkg::DIV_W-1:0]      divisor_reg;
    logic [ppgbd_pkg::DIV_STEP_W-1:0] step_reg;
    logic                             busy_reg;
    logic                             done_reg;

    logic [ppgbd_pkg::DIV_W+1:0] trial;

    assign trial = {1'b0, rem_reg, quo_reg[ppgbd_pkg::DIV_W-1]} - {2'b00, divisor_reg};
    assign rsp   = '{done: done_reg, quotient: quo_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg     <= '0;
            quo_reg     <= '0;
            divisor_reg <= '0;
            step_reg    <= '0;
            busy_reg    <= 1'b0;
            done_reg    <= 1'b0;
        end
        else if (req.start)
        begin
            rem_reg     <= '0;
            quo_reg     <= req.dividend;
            divisor_reg <= req.divisor;
            step_reg    <= '0;
            busy_reg    <= 1'b1;
            done_reg    <= 1'b0;
        end
        else if (busy_reg)
        begin
            // dividend shifts out of the top while quotient bits come in below
            if (!trial[ppgbd_pkg::DIV_W+1])
            begin
                rem_reg <= trial[ppgbd_pkg::DIV_W-1:0];
                quo_reg <= {quo_reg[ppgbd_pkg::DIV_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[ppgbd_pkg::DIV_W-2:0], quo_reg[ppgbd_pkg::DIV_W-1]};
                quo_reg <= {quo_reg[ppgbd_pkg::DIV_W-2:0], 1'b0};
            end
            step_reg <= step_reg + 1'b1;
            if (step_reg == ppgbd_pkg::DIV_STEP_W'(ppgbd_pkg::DIV_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

endmodule

/* rtl/ppgbd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppgbd_back
// Rate back end: beat interval division, rate ring, in-band ring walk and
// averaging, result register towards the output stream.
// ----------------------------------------------------------------------------
module ppgbd_back (
    input  logic                clk,
    input  logic                rst_n,
    input  ppgbd_pkg::cfg_t     cfg,
    input  logic                q_empty,
    input  ppgbd_pkg::event_t   q_head,
    output logic                q_pop,
    output ppgbd_pkg::div_req_t div_req,
    input  ppgbd_pkg::div_rsp_t div_rsp,
    input  logic                out_ready,
    output logic                out_valid,
    output logic                finger_present,
    output logic                beat,
    output logic [15:0]         latest_bpm,
    output logic [7:0]          average_bpm
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BPM_DIV,
        ST_WALK,
        ST_AVG_DIV,
        ST_DONE
    } state_t;

    state_t                         state_reg;
    logic [15:0]                    ring_reg [ppgbd_pkg::RING_DEPTH];
    logic [ppgbd_pkg::SLOT_W-1:0]   slot_reg;
    logic [ppgbd_pkg::SLOT_W-1:0]   idx_reg;
    logic [ppgbd_pkg::SUM_W-1:0]    sum_reg;
    logic [ppgbd_pkg::CNT_W-1:0]    cnt_reg;
    logic [15:0]                    last_bpm_reg;
    logic [7:0]                     avg_reg;
    logic                           present_reg;
    logic                           beat_reg;
    logic                           start_reg;
    logic [ppgbd_pkg::DIV_W-1:0]    dividend_reg;
    logic [ppgbd_pkg::DIV_W-1:0]    divisor_reg;
    logic                           out_valid_reg;
    logic                           out_present_reg;
    logic                           out_beat_reg;
    logic [15:0]                    out_bpm_reg;
    logic [7:0]                     out_avg_reg;

    logic [15:0]                    entry;
    logic                           in_band;
    logic [ppgbd_pkg::SUM_W-1:0]    sum_next;
    logic [ppgbd_pkg::CNT_W-1:0]    cnt_next;
    logic                           load;

    always_comb
    begin
        entry    = ring_reg[idx_reg];
        in_band  = (entry > {8'd0, cfg.bpm_floor}) && (entry < {8'd0, cfg.bpm_ceiling});
        sum_next = in_band ? sum_reg + ppgbd_pkg::SUM_W'(entry[7:0]) : sum_reg;
        cnt_next = in_band ? cnt_reg + 1'b1 : cnt_reg;
        q_pop    = (state_reg == ST_IDLE) && !q_empty;
        load     = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
        div_req  = '{start: start_reg, dividend: dividend_reg, divisor: divisor_reg};
    end

    assign out_valid      = out_valid_reg;
    assign finger_present = out_present_reg;
    assign beat           = out_beat_reg;
    assign latest_bpm     = out_bpm_reg;
    assign average_bpm    = out_avg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            for (int i = 0; i < ppgbd_pkg::RING_DEPTH; i++)
            begin
                ring_reg[i] <= '0;
            end
            slot_reg        <= '0;
            idx_reg         <= '0;
            sum_reg         <= '0;
            cnt_reg         <= '0;
            last_bpm_reg    <= '0;
            avg_reg         <= '0;
            present_reg     <= 1'b0;
            beat_reg        <= 1'b0;
            start_reg       <= 1'b0;
            dividend_reg    <= '0;
            divisor_reg     <= '0;
            out_valid_reg   <= 1'b0;
            out_present_reg <= 1'b0;
            out_beat_reg    <= 1'b0;
            out_bpm_reg     <= '0;
            out_avg_reg     <= '0;
        end
        else
        begin
            case (state_reg)
                ST_IDLE:
                begin
                    if (q_pop)
                    begin
                        present_reg <= q_head.present;
                        beat_reg    <= q_head.beat;
                        idx_reg     <= '0;
                        sum_reg     <= '0;
                        cnt_reg     <= '0;
                        if (!q_head.present)
                        begin
                            // no finger: ring and last rate go back to zero, slot stays
                            for (int i = 0; i < ppgbd_pkg::RING_DEPTH; i++)
                            begin
                                ring_reg[i] <= '0;
                            end
                            last_bpm_reg <= '0;
                            avg_reg      <= '0;
                            state_reg    <= ST_DONE;
                        end
                        else if (q_head.beat)
                        begin
                            dividend_reg <= ppgbd_pkg::BPM_NUMERATOR;
                            divisor_reg  <= (q_head.ms == 16'd0) ? 16'd1 : q_head.ms;
                            start_reg    <= 1'b1;
                            state_reg    <= ST_BPM_DIV;
                        end
                        else
                        begin
                            state_reg <= ST_WALK;
                        end
                    end
                end
                ST_BPM_DIV:
                begin
                    start_reg <= 1'b0;
                    if (div_rsp.done)
                    begin
                        last_bpm_reg       <= div_rsp.quotient;
                        ring_reg[slot_reg] <= div_rsp.quotient;
                        slot_reg           <= (slot_reg == ppgbd_pkg::SLOT_W'(ppgbd_pkg::RING_DEPTH - 1))
                                              ? '0 : slot_reg + 1'b1;
                        state_reg          <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    sum_reg <= sum_next;
                    cnt_reg <= cnt_next;
                    if (idx_reg == ppgbd_pkg::SLOT_W'(ppgbd_pkg::RING_DEPTH - 1))
                    begin
                        idx_reg <= '0;
                        if (cnt_next == '0)
                        begin
                            avg_reg   <= '0;
                            state_reg <= ST_DONE;
                        end
                        else
                        begin
                            dividend_reg <= ppgbd_pkg::DIV_W'(sum_next);
                            divisor_reg  <= ppgbd_pkg::DIV_W'(cnt_next);
                            start_reg    <= 1'b1;
                            state_reg    <= ST_AVG_DIV;
                        end
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                ST_AVG_DIV:
                begin
                    start_reg <= 1'b0;
                    if (div_rsp.done)
                    begin
                        avg_reg   <= div_rsp.quotient[7:0];
                        state_reg <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (load)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            // result register: a waiting result does not hold up the next event
            if (load)
            begin
                out_valid_reg   <= 1'b1;
                out_present_reg <= present_reg;
                out_beat_reg    <= beat_reg;
                out_bpm_reg     <= last_bpm_reg;
                out_avg_reg     <= avg_reg;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

/* rtl/ppg_beat_detector_bpm.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppg_beat_detector_bpm
// Optical pulse beat detector with beat rate ring and in-band rate average.
// ----------------------------------------------------------------------------
// The front end takes one sample per cycle while the queue has room and
// queues a two-entry event list; the back end turns each event into one
// result. A sample with no finger clears the ring and last rate and goes
// straight to the result; a present sample walks the ring, reading one of
// the 8 rate entries per cycle, and divides for the average when some ring
// entry lies in band; a beat first divides 60000 by the beat interval. Both
// divisions use the shared 16-step radix-2 divider. Input is held off while
// the queue is full; a finished result waits in the output register while
// the back end starts on the next event.
// Configuration registers sit on the APB port at byte address 4*i.
module ppg_beat_detector_bpm (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // raw_ir [17:0], filtered_ir [35:18], elapsed_ms [51:36], zero [55:52]
    input  logic [55:0]                   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // latest_bpm [15:0], average_bpm [23:16]
    output logic [23:0]                   m_tdata,
    // finger_present [0], beat [1]
    output logic [1:0]                    m_tuser,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppgbd_pkg::ADDR_W-1:0]  paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    logic [17:0]        presence_reg;
    logic [16:0]        crest_reg;
    logic signed [17:0] trough_reg;
    logic [1:0]         rise_reg;
    logic [7:0]         floor_reg;
    logic [7:0]         ceiling_reg;

    ppgbd_pkg::cfg_t     cfg;
    ppgbd_pkg::event_t   push_data;
    ppgbd_pkg::event_t   q_head;
    ppgbd_pkg::div_req_t div_req;
    ppgbd_pkg::div_rsp_t div_rsp;
    ppgbd_pkg::reg_idx_t reg_idx;
    logic                q_push;
    logic                q_pop;
    logic                q_full;
    logic                q_empty;
    logic                cfg_write;
    logic                finger_present;
    logic                beat;
    logic [15:0]         latest_bpm;
    logic [7:0]          average_bpm;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = ppgbd_pkg::reg_idx_t'(paddr[4:2]);

    assign cfg = '{presence_threshold: presence_reg,
                   crest_level:        crest_reg,
                   trough_level:       trough_reg,
                   rise_needed:        rise_reg,
                   bpm_floor:          floor_reg,
                   bpm_ceiling:        ceiling_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            presence_reg <= ppgbd_pkg::PRESENCE_DEFAULT;
            crest_reg    <= ppgbd_pkg::CREST_DEFAULT;
            trough_reg   <= ppgbd_pkg::TROUGH_DEFAULT;
            rise_reg     <= ppgbd_pkg::RISE_DEFAULT;
            floor_reg    <= ppgbd_pkg::FLOOR_DEFAULT;
            ceiling_reg  <= ppgbd_pkg::CEILING_DEFAULT;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                ppgbd_pkg::REG_PRESENCE: presence_reg <= pwdata[17:0];
                ppgbd_pkg::REG_CREST:    crest_reg    <= pwdata[16:0];
                ppgbd_pkg::REG_TROUGH:   trough_reg   <= $signed(pwdata[17:0]);
                ppgbd_pkg::REG_RISE:     rise_reg     <= pwdata[1:0];
                ppgbd_pkg::REG_FLOOR:    floor_reg    <= pwdata[7:0];
                ppgbd_pkg::REG_CEILING:  ceiling_reg  <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            ppgbd_pkg::REG_PRESENCE: prdata = {14'd0, presence_reg};
            ppgbd_pkg::REG_CREST:    prdata = {15'd0, crest_reg};
            ppgbd_pkg::REG_TROUGH:   prdata = {14'd0, trough_reg};
            ppgbd_pkg::REG_RISE:     prdata = {30'd0, rise_reg};
            ppgbd_pkg::REG_FLOOR:    prdata = {24'd0, floor_reg};
            ppgbd_pkg::REG_CEILING:  prdata = {24'd0, ceiling_reg};
            default:                 prdata = 32'd0;
        endcase
    end

    ppgbd_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .raw_ir      (s_tdata[17:0]),
        .filtered_ir ($signed(s_tdata[35:18])),
        .elapsed_ms  (s_tdata[51:36]),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (push_data)
    );

    ppgbd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (push_data),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    ppgbd_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    ppgbd_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .q_empty        (q_empty),
        .q_head         (q_head),
        .q_pop          (q_pop),
        .div_req        (div_req),
        .div_rsp        (div_rsp),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .finger_present (finger_present),
        .beat           (beat),
        .latest_bpm     (latest_bpm),
        .average_bpm    (average_bpm)
    );

    assign m_tdata = {average_bpm, latest_bpm};
    assign m_tuser = {beat, finger_present};

    // a beat can only come from a sample with a finger on the sensor
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |-> m_tuser[0])
        else $error("beat reported without finger present");

    // with no finger the ring and last rate are cleared, so both rates read zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser[0] |-> m_tdata == 24'd0)
        else $error("nonzero rate reported without finger present");

endmodule

/* sim/ppg_beat_detector_bpm_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppg_beat_detector_bpm_test
// Self-checking bench for the pulse beat detector. Samples go in on the
// slave stream, and a scoreboard predicts one result per accepted sample
// from its own model of the crest/trough/rise machine, the beat rate ring
// and the in-band average. Each result on the master stream is checked
// against it. The bench runs a directed part and then random pulse
// waveforms with noise, absent fingers and long intervals, under several
// register settings. Except in one phase each, both streams idle at random.
// ----------------------------------------------------------------------------
module ppg_beat_detector_bpm_test;

    import ppgbd_pkg::*;

    localparam int TAIL_CYCLES = 100;
    localparam int DRAIN_GUARD = 100000;
    localparam int RUN_LIMIT_NS = 25_000_000;

    typedef struct packed {
        logic        present;
        logic        beat;
        logic [15:0] latest_bpm;
        logic [7:0]  average_bpm;
    } pulse_result_t;

    class pulse_scoreboard;
        logic [17:0]        presence_threshold;
        logic [16:0]        crest_level;
        logic signed [17:0] trough_level;
        logic [1:0]         rise_needed;
        logic [7:0]         bpm_floor;
        logic [7:0]         bpm_ceiling;

        logic signed [17:0] previous_sample;
        logic               previous_valid;
        logic               crest_seen;
        logic               trough_seen;
        logic [1:0]         rise_count;
        logic signed [17:0] running_max;
        logic signed [17:0] running_min;
        logic [15:0]        ms_since_beat;
        logic [15:0]        rate_ring [RING_DEPTH];
        int                 ring_slot;
        logic [15:0]        last_bpm;

        pulse_result_t      expected_pulses [$];
        int                 failures;

        function new();
            presence_threshold = PRESENCE_DEFAULT;
            crest_level        = CREST_DEFAULT;
            trough_level       = TROUGH_DEFAULT;
            rise_needed        = RISE_DEFAULT;
            bpm_floor          = FLOOR_DEFAULT;
            bpm_ceiling        = CEILING_DEFAULT;
            ring_slot          = 0;
            failures           = 0;
            clear_detection();
        endfunction

        function void clear_detection();
            previous_sample = '0;
            previous_valid  = 1'b0;
            crest_seen      = 1'b0;
            trough_seen     = 1'b0;
            rise_count      = '0;
            running_max     = MAX_RESET;
            running_min     = MIN_RESET;
            ms_since_beat   = '0;
            last_bpm        = '0;
            for (int i = 0; i < RING_DEPTH; i++)
                rate_ring[i] = '0;
        endfunction

        function void set_register(reg_idx_t idx, logic [31:0] value);
            case (idx)
                REG_PRESENCE: presence_threshold = value[17:0];
                REG_CREST:    crest_level        = value[16:0];
                REG_TROUGH:   trough_level       = value[17:0];
                REG_RISE:     rise_needed        = value[1:0];
                REG_FLOOR:    bpm_floor          = value[7:0];
                REG_CEILING:  bpm_ceiling        = value[7:0];
                default:      ;
            endcase
        endfunction

        function void note_failure(string what);
            if (failures < 10)
                $display("mismatch at %0t: %s", $realtime, what);
            failures++;
        endfunction

        // one accepted sample: advance the detector and queue its result
        function void note_sample(logic [17:0] raw, logic signed [17:0] filt,
                                  logic [15:0] ms);
            pulse_result_t predicted;
            logic [16:0]   ms_sum;
            logic          beat_now;
            int            interval;
            int            total;
            int            count;
            beat_now          = 1'b0;
            predicted.present = (raw >= presence_threshold);
            if (!predicted.present)
                clear_detection();
            else
            begin
                ms_sum        = {1'b0, ms_since_beat} + {1'b0, ms};
                ms_since_beat = ms_sum[16] ? 16'hFFFF : ms_sum[15:0];
                if (previous_valid)
                begin
                    if (crest_seen && trough_seen && filt > previous_sample)
                    begin
                        // wraps at four, never cleared by a falling sample
                        rise_count = rise_count + 2'd1;
                        if (rise_count >= rise_needed)
                        begin
                            beat_now    = 1'b1;
                            crest_seen  = 1'b0;
                            trough_seen = 1'b0;
                            rise_count  = '0;
                            running_max = MAX_RESET;
                            running_min = MIN_RESET;
                        end
                    end
                    if (!beat_now)
                    begin
                        if (filt > running_max)
                        begin
                            running_max = filt;
                            if (filt > $signed({1'b0, crest_level}))
                                crest_seen = 1'b1;
                        end
                        if (crest_seen && filt < running_min)
                        begin
                            running_min = filt;
                            if (filt < trough_level)
                                trough_seen = 1'b1;
                        end
                    end
                end
                if (beat_now)
                begin
                    interval             = (ms_since_beat == 0) ? 1 : int'(ms_since_beat);
                    last_bpm             = 16'(int'(BPM_NUMERATOR) / interval);
                    rate_ring[ring_slot] = last_bpm;
                    ring_slot            = (ring_slot + 1) % RING_DEPTH;
                    ms_since_beat        = '0;
                end
                previous_sample = filt;
                previous_valid  = 1'b1;
            end
            total = 0;
            count = 0;
            for (int i = 0; i < RING_DEPTH; i++)
            begin
                if (rate_ring[i] > bpm_floor && rate_ring[i] < bpm_ceiling)
                begin
                    total += rate_ring[i];
                    count++;
                end
            end
            predicted.beat        = beat_now;
            predicted.latest_bpm  = last_bpm;
            predicted.average_bpm = (count == 0) ? 8'd0 : 8'(total / count);
            expected_pulses.push_back(predicted);
        endfunction

        function void check_result(logic [23:0] data, logic [1:0] user);
            pulse_result_t predicted;
            if (expected_pulses.size() == 0)
            begin
                note_failure($sformatf("result with none expected: present %0b beat %0b bpm %0d avg %0d",
                                       user[0], user[1], data[15:0], data[23:16]));
                return;
            end
            predicted = expected_pulses.pop_front();
            if (user[0] !== predicted.present || user[1] !== predicted.beat ||
                data[15:0] !== predicted.latest_bpm || data[23:16] !== predicted.average_bpm)
                note_failure($sformatf({"expected present %0b beat %0b bpm %0d avg %0d,",
                                        " got present %0b beat %0b bpm %0d avg %0d"},
                                       predicted.present, predicted.beat,
                                       predicted.latest_bpm, predicted.average_bpm,
                                       user[0], user[1], data[15:0], data[23:16]));
        endfunction

        function int pending();
            return expected_pulses.size();
        endfunction

        function void close_out();
            if (expected_pulses.size() != 0)
                note_failure($sformatf("%0d results never arrived", expected_pulses.size()));
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [55:0]        s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [23:0]        m_tdata;
    logic [1:0]         m_tuser;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [ADDR_W-1:0]  paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;

    pulse_scoreboard    sb;
    bit                 feed_gaps;
    bit                 sink_stalls;

    ppg_beat_detector_bpm i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // mostly short idles, now and then a long one
    function int idle_length();
        if ($urandom_range(0, 99) < 90)
            return $urandom_range(1, 3);
        return $urandom_range(20, 120);
    endfunction

    task send_sample(input logic [17:0] raw, input logic signed [17:0] filt,
                     input logic [15:0] ms);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, ms, filt, raw};
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_sample(raw, filt, ms);
        gap = (feed_gaps && $urandom_range(0, 99) >= 60) ? idle_length() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // write, then read back over the same selection
    task program_register(input reg_idx_t idx, input logic [31:0] value, input int width);
        logic [31:0] mask;
        mask    = (32'd1 << width) - 32'd1;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'(4 * int'(idx));
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        sb.set_register(idx, value);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        if ((prdata & mask) !== (value & mask))
            sb.note_failure($sformatf("register %s read %0h, written %0h",
                                      idx.name(), prdata & mask, value & mask));
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task wait_drained();
        int guard;
        guard    = 0;
        s_tvalid <= 1'b0;
        while (sb.pending() != 0 && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task apply_setting(input int presence, input int crest, input int trough,
                       input int rise, input int floor_bpm, input int ceiling_bpm);
        wait_drained();
        program_register(REG_PRESENCE, 32'(presence), 18);
        program_register(REG_CREST, 32'(crest), 17);
        program_register(REG_TROUGH, 32'(trough), 18);
        program_register(REG_RISE, 32'(rise), 2);
        program_register(REG_FLOOR, 32'(floor_bpm), 8);
        program_register(REG_CEILING, 32'(ceiling_bpm), 8);
    endtask

    // triangle pulses with jitter, broken up by noise, absence and long intervals
    task send_random_items(input int count);
        int          pos;
        int          period;
        int          half;
        int          base_ms;
        int          amp;
        int          v;
        int          kind;
        int          thr;
        logic [17:0] raw;
        logic [17:0] filt;
        logic [15:0] ms;
        pos    = 0;
        period = 1;
        half   = 1;
        amp    = 1;
        base_ms = 0;
        for (int n = 0; n < count; n++)
        begin
            thr = sb.presence_threshold;
            if (pos == 0)
            begin
                period  = $urandom_range(6, 40);
                half    = period / 2;
                base_ms = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(10, 70);
                amp     = int'(sb.crest_level);
                if (-int'(sb.trough_level) > amp)
                    amp = -int'(sb.trough_level);
                amp = amp + $urandom_range(1, 3000);
                if (amp > 131071)
                    amp = 131071;
            end
            if (pos < half)
                v = -amp + (2 * amp * pos) / half;
            else
                v = amp - (2 * amp * (pos - half)) / (period - half);
            v = v + int'($urandom_range(0, amp / 8)) - amp / 16;
            if (v > 131071)
                v = 131071;
            if (v < -131072)
                v = -131072;
            filt = 18'(v);
            raw  = 18'(thr + int'($urandom_range(0, 262143 - thr)));
            ms   = (base_ms == 0) ? 16'd0 : 16'(base_ms + int'($urandom_range(0, 4)));
            kind = $urandom_range(0, 99);
            if (kind >= 80 && kind < 88)
            begin
                raw  = 18'($urandom);
                filt = 18'($urandom);
                ms   = 16'($urandom);
            end
            else if (kind >= 88 && kind < 94)
            begin
                if (thr > 0)
                    raw = 18'($urandom_range(0, thr - 1));
                else
                    filt = 18'($urandom);
            end
            else if (kind >= 94)
                ms = 16'($urandom);
            pos = (pos + 1) % period;
            send_sample(raw, filt, ms);
        end
    endtask

    initial
    begin
        int phase_items;
        sb          = new();
        feed_gaps   = 1'b1;
        sink_stalls = 1'b1;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part at the reset settings
        send_sample(18'd0, -18'sd131072, 16'd65535);
        send_sample(18'd262143, 18'sd131071, 16'd0);
        send_sample(18'd150000, 18'sd200, 16'd0);
        send_sample(18'd150000, -18'sd200, 16'd0);
        send_sample(18'd150000, 18'sd0, 16'd0);
        // a falling sample keeps the rise count, zero interval gives 60000
        send_sample(18'd150000, -18'sd50, 16'd0);
        send_sample(18'd150000, 18'sd10, 16'd0);
        send_sample(18'd150000, 18'sd300, 16'd250);
        send_sample(18'd150000, -18'sd300, 16'd250);
        send_sample(18'd150000, -18'sd100, 16'd125);
        send_sample(18'd150000, 18'sd0, 16'd125);
        // saturated interval
        send_sample(18'd150000, 18'sd500, 16'd65535);
        send_sample(18'd150000, -18'sd500, 16'd65535);
        send_sample(18'd150000, 18'sd0, 16'd0);
        send_sample(18'd150000, 18'sd100, 16'd0);
        // finger lost, then exactly at threshold
        send_sample(18'd99999, 18'sd5, 16'd7);
        send_sample(18'd100000, 18'sd5, 16'd7);
        // zero rise count needed and an empty band
        apply_setting(100000, 100, -100, 0, 200, 10);
        send_sample(18'd200000, 18'sd1000, 16'd100);
        send_sample(18'd200000, -18'sd1000, 16'd100);
        send_sample(18'd200000, -18'sd900, 16'd100);

        for (int p = 0; p < 7; p++)
        begin
            feed_gaps   = (p != 1);
            sink_stalls = (p != 3);
            phase_items = 260;
            case (p)
                0: apply_setting(100000, 100, -100, 2, 45, 150);
                1: apply_setting(0, 0, 0, 1, 0, 255);
                2:
                begin
                    apply_setting(262143, 131071, -131072, 3, 255, 0);
                    phase_items = 100;
                end
                3: apply_setting(50000, 500, -500, 3, 60, 120);
                4: apply_setting(120000, 50, -50, 0, 45, 150);
                default: apply_setting($urandom_range(0, 150000), $urandom_range(0, 4000),
                                       -int'($urandom_range(0, 4000)), $urandom_range(0, 3),
                                       $urandom_range(0, 100), $urandom_range(60, 255));
            endcase
            send_random_items(phase_items);
        end

        wait_drained();
        sb.close_out();
        if (sb.failures == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // result side: random back-pressure unless stalls are off, every transfer checked
    initial
    begin
        int  hold;
        bit  next_ready;
        hold = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                sb.check_result(m_tdata, m_tuser);
            if (hold > 0)
                hold--;
            else
            begin
                next_ready = !sink_stalls || ($urandom_range(0, 99) < 60);
                m_tready <= next_ready;
                hold = next_ready ? $urandom_range(0, 7) : idle_length();
            end
        end
    end

    initial
    begin
        #(RUN_LIMIT_NS);
        $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
rtl/ppgbd_pkg.sv
rtl/ppgbd_front.sv
rtl/ppgbd_queue.sv
rtl/ppgbd_div.sv
rtl/ppgbd_back.sv
rtl/ppg_beat_detector_bpm.sv
sim/ppg_beat_detector_bpm_test.sv
